// ===== hw/rtl/fkcrc_pkg.sv =====
// Package for the flow key CRC-32 hash: types, register codes and the byte-wide CRC step.
package fkcrc_pkg;

   localparam int unsigned CRC_WIDTH        = 32;
   localparam int unsigned FIELD_WIDTH      = 31;
   localparam int unsigned BYTE_WIDTH       = 8;
   localparam int unsigned CSR_INDEX_WIDTH  = 1;
   localparam int unsigned CSR_DATA_WIDTH   = 5;
   localparam int unsigned COUNT_WIDTH      = 5;

   typedef logic [CRC_WIDTH-1:0]       crc_type;
   typedef logic [1:0]                 poly_sel_type;
   typedef logic [COUNT_WIDTH-1:0]     count_type;
   typedef logic [CSR_INDEX_WIDTH-1:0] csr_index_type;

   localparam csr_index_type CSR_POLY_SELECT     = 1'b0;
   localparam csr_index_type CSR_INDEX_BIT_COUNT = 1'b1;

   localparam poly_sel_type POLY_SELECT_RESET     = 2'd0;
   localparam count_type    INDEX_BIT_COUNT_RESET = 5'd21;
   localparam count_type    INDEX_BIT_COUNT_MIN   = 5'd1;

   localparam poly_sel_type POLY_CRC32   = 2'd0;
   localparam poly_sel_type POLY_CRC32C  = 2'd1;
   localparam poly_sel_type POLY_CRC32K  = 2'd2;
   localparam poly_sel_type POLY_CRC32Q  = 2'd3;

   function automatic crc_type poly_value(input poly_sel_type sel);
      crc_type poly;
      case (sel)
         POLY_CRC32:  poly = 32'h04C1_1DB7;
         POLY_CRC32C: poly = 32'h1EDC_6F41;
         POLY_CRC32K: poly = 32'h741B_8CD7;
         POLY_CRC32Q: poly = 32'h8141_41AB;
         default:     poly = 32'h04C1_1DB7;
      endcase
      return poly;
   endfunction

   // MSB-first update of the CRC by one byte.
   function automatic crc_type crc_byte(input crc_type crc_cur,
                                        input logic [BYTE_WIDTH-1:0] data,
                                        input crc_type poly);
      crc_type c;
      c = crc_cur ^ {data, {(CRC_WIDTH-BYTE_WIDTH){1'b0}}};
      for (int b = 0; b < BYTE_WIDTH; b++) begin
         if (c[CRC_WIDTH-1]) begin
            c = {c[CRC_WIDTH-2:0], 1'b0} ^ poly;
         end else begin
            c = {c[CRC_WIDTH-2:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

// ===== hw/rtl/flow_key_crc_hash_split_core.sv =====
// Flow key CRC-32 hash core: per-byte CRC update, key-end result register and index/tag split.
//
// Key bytes enter one per transaction, first byte first, and a new byte is taken in every
// cycle unless the receiver stalls a held result; the byte-wide CRC update against the
// running CRC register sets that rate. The transaction that carries the last byte of a
// key loads the result register, so the hash, table index and hash tag appear on the
// result channel in the cycle after that byte is accepted, and the CRC register restarts
// at zero for the next key. Bytes other than the last produce no result. The polynomial
// select takes effect from the next byte on; both registers are meant to be written only
// while no key result is outstanding. An index bit count of zero is treated as one.
module flow_key_crc_hash_split_core (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [fkcrc_pkg::BYTE_WIDTH-1:0]       req_key_byte,
   input  logic                                   req_last_byte,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [fkcrc_pkg::CRC_WIDTH-1:0]        rsp_hash_value,
   output logic [fkcrc_pkg::FIELD_WIDTH-1:0]      rsp_table_index,
   output logic [fkcrc_pkg::FIELD_WIDTH-1:0]      rsp_hash_tag,
   input  logic                                   csr_write_enable,
   input  logic [fkcrc_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [fkcrc_pkg::CSR_DATA_WIDTH-1:0]   csr_write_data
);

   fkcrc_pkg::crc_type      crc_ff, crc_in;
   fkcrc_pkg::crc_type      hash_ff, hash_in;
   fkcrc_pkg::count_type    count_ff, count_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   fkcrc_pkg::poly_sel_type poly_sel_ff, poly_sel_in;
   fkcrc_pkg::count_type    idx_count_ff, idx_count_in;

   logic                    req_accept;
   fkcrc_pkg::crc_type      crc_next;
   fkcrc_pkg::count_type    count_eff;
   logic [fkcrc_pkg::FIELD_WIDTH-1:0] index_mask;

   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;

   assign crc_next  = fkcrc_pkg::crc_byte(crc_ff, req_key_byte,
                                          fkcrc_pkg::poly_value(poly_sel_ff));
   assign count_eff = (idx_count_ff < fkcrc_pkg::INDEX_BIT_COUNT_MIN)
                      ? fkcrc_pkg::INDEX_BIT_COUNT_MIN : idx_count_ff;

   // csr writes
   always_comb begin
      poly_sel_in  = poly_sel_ff;
      idx_count_in = idx_count_ff;
      if (csr_write_enable) begin
         case (csr_index)
            fkcrc_pkg::CSR_POLY_SELECT:     poly_sel_in  = csr_write_data[1:0];
            fkcrc_pkg::CSR_INDEX_BIT_COUNT: idx_count_in = csr_write_data;
            default: ;
         endcase
      end
   end

   // hash datapath and result register
   always_comb begin
      crc_in       = crc_ff;
      hash_in      = hash_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff;
      if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (req_accept) begin
         if (req_last_byte) begin
            crc_in       = '0;
            hash_in      = crc_next;
            count_in     = count_eff;
            rsp_valid_in = 1'b1;
         end else begin
            crc_in = crc_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         poly_sel_ff  <= fkcrc_pkg::POLY_SELECT_RESET;
         idx_count_ff <= fkcrc_pkg::INDEX_BIT_COUNT_RESET;
      end else begin
         crc_ff       <= crc_in;
         rsp_valid_ff <= rsp_valid_in;
         poly_sel_ff  <= poly_sel_in;
         idx_count_ff <= idx_count_in;
      end
   end

   always_ff @(posedge clock) begin
      hash_ff  <= hash_in;
      count_ff <= count_in;
   end

   assign index_mask      = ~({fkcrc_pkg::FIELD_WIDTH{1'b1}} << count_ff);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_hash_value  = hash_ff;
   assign rsp_table_index = hash_ff[fkcrc_pkg::FIELD_WIDTH-1:0] & index_mask;
   assign rsp_hash_tag    = fkcrc_pkg::FIELD_WIDTH'(hash_ff >> count_ff);

`ifndef SYNTH
   a_last_loads_result: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_last_byte |=> rsp_valid_ff)
      else $error("key end did not produce a result");

   a_last_clears_crc: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_last_byte |=> crc_ff == '0)
      else $error("crc register not cleared after key end");

   a_no_spurious_result: assert property (@(posedge clock) disable iff (reset)
      !(req_accept && req_last_byte) && !rsp_stall |=> !rsp_valid_ff)
      else $error("result valid without a key end");

   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> count_ff != '0)
      else $error("index bit count of zero reached the result");
`endif

endmodule

// ===== bench/tb.sv =====
// Testbench for flow_key_crc_hash_split_core: directed and random keys against a CRC-32 predictor.
module tb;

   localparam int CYCLE_LIMIT = 300000;
   localparam int HOLD_CYCLES = 200;

   typedef struct packed {
      logic [fkcrc_pkg::BYTE_WIDTH-1:0] key_byte;
      logic                             last_byte;
   } key_item_type;

   typedef struct packed {
      fkcrc_pkg::crc_type                hash_value;
      logic [fkcrc_pkg::FIELD_WIDTH-1:0] table_index;
      logic [fkcrc_pkg::FIELD_WIDTH-1:0] hash_tag;
   } key_hash_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [fkcrc_pkg::BYTE_WIDTH-1:0] req_key_byte = '0;
   logic req_last_byte = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [fkcrc_pkg::CRC_WIDTH-1:0] rsp_hash_value;
   logic [fkcrc_pkg::FIELD_WIDTH-1:0] rsp_table_index;
   logic [fkcrc_pkg::FIELD_WIDTH-1:0] rsp_hash_tag;
   logic csr_write_enable = 1'b0;
   logic [fkcrc_pkg::CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [fkcrc_pkg::CSR_DATA_WIDTH-1:0] csr_write_data = '0;

   key_item_type pending_bytes[$];
   key_hash_type key_hashes_due[$];

   fkcrc_pkg::crc_type generator [4] = '{32'h04C1_1DB7, 32'h1EDC_6F41,
                                         32'h741B_8CD7, 32'h8141_41AB};
   fkcrc_pkg::crc_type      running_crc = '0;
   fkcrc_pkg::poly_sel_type cur_poly = fkcrc_pkg::POLY_SELECT_RESET;
   fkcrc_pkg::count_type    cur_count = fkcrc_pkg::INDEX_BIT_COUNT_RESET;

   int  error_count = 0;
   int  cycle_count = 0;
   int  send_gap = 0;
   int  recv_gap = 0;
   int  hold_left = 0;
   bit  idling_on = 1'b1;
   bit  hold_request = 1'b0;
   bit  hold_taken = 1'b0;
   key_hash_type got;
   key_hash_type want;
   key_item_type next_item;

   flow_key_crc_hash_split_core i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_key_byte     (req_key_byte),
      .req_last_byte    (req_last_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_hash_value   (rsp_hash_value),
      .rsp_table_index  (rsp_table_index),
      .rsp_hash_tag     (rsp_hash_tag),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #5 clock = ~clock;

   // bit-serial MSB-first CRC: feedback is the top CRC bit xor the incoming data bit
   function automatic fkcrc_pkg::crc_type fold_byte(fkcrc_pkg::crc_type crc,
                                                    logic [fkcrc_pkg::BYTE_WIDTH-1:0] data,
                                                    fkcrc_pkg::crc_type poly);
      logic feedback;
      for (int i = fkcrc_pkg::BYTE_WIDTH - 1; i >= 0; i--) begin
         feedback = crc[fkcrc_pkg::CRC_WIDTH-1] ^ data[i];
         crc = {crc[fkcrc_pkg::CRC_WIDTH-2:0], 1'b0} ^ (feedback ? poly : '0);
      end
      return crc;
   endfunction

   function automatic key_hash_type split_hash(fkcrc_pkg::crc_type hash,
                                               fkcrc_pkg::count_type count);
      key_hash_type r;
      int unsigned k;
      fkcrc_pkg::crc_type mask;
      k = (count == 0) ? 1 : count;
      mask = (32'h1 << k) - 32'h1;
      r.hash_value  = hash;
      r.table_index = fkcrc_pkg::FIELD_WIDTH'(hash & mask);
      r.hash_tag    = fkcrc_pkg::FIELD_WIDTH'(hash >> k);
      return r;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            running_crc = fold_byte(running_crc, req_key_byte, generator[cur_poly]);
            if (req_last_byte) begin
               key_hashes_due.push_back(split_hash(running_crc, cur_count));
               running_crc = '0;
            end
         end
         if (!req_valid || !req_stall) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending_bytes.size() != 0) begin
               next_item = pending_bytes.pop_front();
               req_valid     <= 1'b1;
               req_key_byte  <= next_item.key_byte;
               req_last_byte <= next_item.last_byte;
               if (idling_on && $urandom_range(0, 7) == 0) begin
                  send_gap = $urandom_range(1, 16);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor and receiver stall
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got.hash_value  = rsp_hash_value;
            got.table_index = rsp_table_index;
            got.hash_tag    = rsp_hash_tag;
            if (key_hashes_due.size() == 0) begin
               $error("result transaction with nothing expected: hash_value %h", got.hash_value);
               error_count++;
            end else begin
               want = key_hashes_due.pop_front();
               if (got.hash_value !== want.hash_value) begin
                  $error("hash_value: expected %h, got %h", want.hash_value, got.hash_value);
                  error_count++;
               end
               if (got.table_index !== want.table_index) begin
                  $error("table_index: expected %h, got %h", want.table_index, got.table_index);
                  error_count++;
               end
               if (got.hash_tag !== want.hash_tag) begin
                  $error("hash_tag: expected %h, got %h", want.hash_tag, got.hash_tag);
                  error_count++;
               end
            end
         end
         if (hold_request && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (recv_gap > 0) begin
            recv_gap--;
            rsp_stall <= 1'b1;
         end else if (idling_on && $urandom_range(0, 7) == 0) begin
            recv_gap = $urandom_range(0, 15);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   function automatic void push_byte(logic [fkcrc_pkg::BYTE_WIDTH-1:0] b, logic last);
      key_item_type item;
      item.key_byte  = b;
      item.last_byte = last;
      pending_bytes.push_back(item);
   endfunction

   // random keys, the last one left open when open_tail is set
   function automatic void queue_keys(int n_items, bit open_tail);
      int left;
      int len;
      logic [fkcrc_pkg::BYTE_WIDTH-1:0] b;
      left = n_items;
      while (left > 0) begin
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
         if (len > left) len = left;
         for (int i = 0; i < len; i++) begin
            case ($urandom_range(0, 15))
               0:       b = 8'h00;
               1:       b = 8'hFF;
               default: b = fkcrc_pkg::BYTE_WIDTH'($urandom);
            endcase
            push_byte(b, (i == len - 1) && !(open_tail && left == len));
         end
         left -= len;
      end
   endfunction

   task automatic settle();
      do @(negedge clock);
      while (pending_bytes.size() != 0 || req_valid || key_hashes_due.size() != 0);
      repeat (3) @(negedge clock);
   endtask

   task automatic write_reg(fkcrc_pkg::csr_index_type idx,
                            logic [fkcrc_pkg::CSR_DATA_WIDTH-1:0] data);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (idx == fkcrc_pkg::CSR_POLY_SELECT) cur_poly = fkcrc_pkg::poly_sel_type'(data[1:0]);
      else cur_count = fkcrc_pkg::count_type'(data);
      @(negedge clock);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset settings; single-byte keys and one three-byte key
      push_byte(8'h00, 1'b1);
      push_byte(8'hFF, 1'b1);
      push_byte(8'h80, 1'b0);
      push_byte(8'h01, 1'b0);
      push_byte(8'hAA, 1'b1);
      push_byte(8'h5A, 1'b1);
      settle();
      // zero index count acts as one
      write_reg(fkcrc_pkg::CSR_INDEX_BIT_COUNT, 5'd0);
      write_reg(fkcrc_pkg::CSR_POLY_SELECT, fkcrc_pkg::POLY_CRC32Q);
      push_byte(8'hFF, 1'b0);
      push_byte(8'h55, 1'b1);
      push_byte(8'hFF, 1'b1);
      settle();
      write_reg(fkcrc_pkg::CSR_INDEX_BIT_COUNT, 5'd31);
      write_reg(fkcrc_pkg::CSR_POLY_SELECT, fkcrc_pkg::POLY_CRC32C);
      push_byte(8'h12, 1'b0);
      push_byte(8'h34, 1'b1);
      push_byte(8'hFF, 1'b1);
      settle();
      // polynomial switched in the middle of a key
      write_reg(fkcrc_pkg::CSR_INDEX_BIT_COUNT, 5'd1);
      push_byte(8'hC3, 1'b0);
      push_byte(8'h3C, 1'b0);
      settle();
      write_reg(fkcrc_pkg::CSR_POLY_SELECT, fkcrc_pkg::POLY_CRC32K);
      push_byte(8'h7E, 1'b1);
      push_byte(8'h00, 1'b1);
      settle();

      for (int p = 0; p < 8; p++) begin
         write_reg(fkcrc_pkg::CSR_POLY_SELECT, fkcrc_pkg::poly_sel_type'(p % 4));
         case (p)
            0:       write_reg(fkcrc_pkg::CSR_INDEX_BIT_COUNT, 5'd1);
            1:       write_reg(fkcrc_pkg::CSR_INDEX_BIT_COUNT, 5'd31);
            2:       write_reg(fkcrc_pkg::CSR_INDEX_BIT_COUNT, 5'd0);
            default: write_reg(fkcrc_pkg::CSR_INDEX_BIT_COUNT, 5'($urandom_range(1, 31)));
         endcase
         if (p % 2 == 1) begin
            queue_keys(32, 1'b1);
            settle();
            write_reg(fkcrc_pkg::CSR_POLY_SELECT,
                      fkcrc_pkg::poly_sel_type'($urandom_range(0, 3)));
            queue_keys(12, 1'b0);
         end else begin
            queue_keys(44, 1'b0);
         end
         settle();
      end

      // long receiver hold while bytes keep coming
      idling_on = 1'b0;
      write_reg(fkcrc_pkg::CSR_INDEX_BIT_COUNT, 5'($urandom_range(1, 31)));
      hold_request = 1'b1;
      queue_keys(40, 1'b0);
      settle();

      // closing stretch without idling
      write_reg(fkcrc_pkg::CSR_POLY_SELECT, fkcrc_pkg::poly_sel_type'($urandom_range(0, 3)));
      queue_keys(50, 1'b0);
      settle();
      repeat (5) @(negedge clock);

      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
